// ===== src/abi_pkg.sv =====
// Shared types, register codes and saturating fixed-point helpers for the boundary impulse block.
package abi_pkg;

    localparam int unsigned Q_FRAC     = 16;
    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned NUM_FACES  = 6;
    localparam int unsigned PIPE_DEPTH = 7;

    localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;
    localparam logic [63:0] LIMITS_RST = 64'h7FFF_FFFF_8000_0000;

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        q_t pos_x;
        q_t pos_y;
        q_t pos_z;
        q_t vel_x;
        q_t vel_y;
        q_t vel_z;
    } abi_in_t;

    typedef struct packed {
        q_t new_vel_x;
        q_t new_vel_y;
        q_t new_vel_z;
        q_t mid_vel_x;
        q_t mid_vel_y;
        q_t mid_vel_z;
    } abi_out_t;

    typedef struct packed {
        logic [63:0] limits_x;
        logic [63:0] limits_y;
        logic [63:0] limits_z;
        logic [30:0] sim_scale;
        logic [17:0] restitution_factor;
        logic [16:0] friction;
        logic [30:0] position_gain;
    } abi_cfg_t;

    typedef struct packed {
        logic advance;
        logic in_valid;
    } abi_ctrl_t;

    typedef enum logic [2:0] {
        REG_LIMITS_X      = 3'd0,
        REG_LIMITS_Y      = 3'd1,
        REG_LIMITS_Z      = 3'd2,
        REG_SIM_SCALE     = 3'd3,
        REG_RESTITUTION   = 3'd4,
        REG_FRICTION      = 3'd5,
        REG_POSITION_GAIN = 3'd6
    } abi_reg_t;

    // Clamp an exact wide value to 32-bit signed.
    function automatic q_t sat32(input logic signed [63:0] x);
        q_t r;
        if (x > S32_MAX_W) begin
            r = q_t'(S32_MAX_W[31:0]);
        end else if (x < S32_MIN_W) begin
            r = q_t'(S32_MIN_W[31:0]);
        end else begin
            r = q_t'(x[31:0]);
        end
        return r;
    endfunction

    // Finish a Q16.16 product: floor shift, then clamp.
    function automatic q_t qfinish(input logic signed [63:0] p);
        return sat32(p >>> Q_FRAC);
    endfunction

endpackage

// ===== src/abi_core.sv =====
// Seven-stage datapath: scale, face distances, products, contributions, accumulation, output.
module abi_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  abi_pkg::abi_cfg_t  cfg,
    input  abi_pkg::abi_ctrl_t ctrl,
    input  abi_pkg::abi_in_t   in_item,
    output logic              out_valid,
    output abi_pkg::abi_out_t  out_item
);
    import abi_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;

    // operand views of the registers
    logic signed [31:0] scale_s;
    logic signed [17:0] fric_s;
    logic signed [18:0] rest_s;
    logic signed [31:0] gain_s;
    q_t lim_lo [NUM_AXES];
    q_t lim_hi [NUM_AXES];

    assign scale_s = signed'({1'b0, cfg.sim_scale});
    assign fric_s  = signed'({1'b0, cfg.friction});
    assign rest_s  = signed'({1'b0, cfg.restitution_factor});
    assign gain_s  = signed'({1'b0, cfg.position_gain});
    assign lim_lo[0] = q_t'(cfg.limits_x[31:0]);
    assign lim_hi[0] = q_t'(cfg.limits_x[63:32]);
    assign lim_lo[1] = q_t'(cfg.limits_y[31:0]);
    assign lim_hi[1] = q_t'(cfg.limits_y[63:32]);
    assign lim_lo[2] = q_t'(cfg.limits_z[31:0]);
    assign lim_hi[2] = q_t'(cfg.limits_z[63:32]);

    // ---------------- stage 1: scale and friction products ----------------
    q_t pos_in [NUM_AXES];
    q_t vel_in [NUM_AXES];
    logic signed [63:0] sprod_next  [NUM_AXES];
    logic signed [49:0] vfprod_next [NUM_AXES];
    logic signed [63:0] sprod_reg   [NUM_AXES];
    logic signed [49:0] vfprod_reg  [NUM_AXES];
    q_t vel1_reg [NUM_AXES];

    assign pos_in[0] = in_item.pos_x;
    assign pos_in[1] = in_item.pos_y;
    assign pos_in[2] = in_item.pos_z;
    assign vel_in[0] = in_item.vel_x;
    assign vel_in[1] = in_item.vel_y;
    assign vel_in[2] = in_item.vel_z;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            sprod_next[a]  = pos_in[a] * scale_s;
            vfprod_next[a] = vel_in[a] * fric_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                sprod_reg[a]  <= sprod_next[a];
                vfprod_reg[a] <= vfprod_next[a];
                vel1_reg[a]   <= vel_in[a];
            end
        end
    end

    // ---------------- stage 2: face distances, penetrating and tangential speed ----------------
    q_t s2 [NUM_AXES];
    q_t d2 [NUM_FACES];
    q_t vneg2 [NUM_AXES];
    logic signed [32:0] negd_next [NUM_FACES];
    q_t pm_next   [NUM_FACES];
    q_t tang_next [NUM_FACES];
    logic [NUM_FACES-1:0] act_next;
    q_t cf_next   [NUM_AXES];

    logic signed [32:0] negd_reg [NUM_FACES];
    q_t pm_reg   [NUM_FACES];
    q_t tang_reg [NUM_FACES];
    logic [NUM_FACES-1:0] act2_reg;
    q_t cf2_reg  [NUM_AXES];
    q_t vel2_reg [NUM_AXES];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            s2[a]    = qfinish(sprod_reg[a]);
            cf_next[a] = sat32(-64'(qfinish(64'(vfprod_reg[a]))));
            vneg2[a] = sat32(-64'(vel1_reg[a]));
            d2[2*a]   = sat32(64'(s2[a]) - 64'(lim_lo[a]));
            d2[2*a+1] = sat32(64'(lim_hi[a]) - 64'(s2[a]));
            // lower face pushes along +axis, upper along -axis
            pm_next[2*a]   = vneg2[a] < 0 ? '0 : vneg2[a];
            pm_next[2*a+1] = vel1_reg[a] < 0 ? '0 : vel1_reg[a];
            tang_next[2*a]   = sat32(64'(vel1_reg[a]) + 64'(pm_next[2*a]));
            tang_next[2*a+1] = sat32(64'(vel1_reg[a]) - 64'(pm_next[2*a+1]));
        end
        for (int f = 0; f < NUM_FACES; f++) begin
            act_next[f]  = d2[f] < 0;
            negd_next[f] = -33'(d2[f]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            for (int f = 0; f < NUM_FACES; f++) begin
                negd_reg[f] <= negd_next[f];
                pm_reg[f]   <= pm_next[f];
                tang_reg[f] <= tang_next[f];
            end
            act2_reg <= act_next;
            for (int a = 0; a < NUM_AXES; a++) begin
                cf2_reg[a]  <= cf_next[a];
                vel2_reg[a] <= vel1_reg[a];
            end
        end
    end

    // ---------------- stage 3: restitution, position and friction products ----------------
    logic signed [50:0] pr_next [NUM_FACES];
    logic signed [64:0] pg_next [NUM_FACES];
    logic signed [49:0] pt_next [NUM_FACES];
    logic signed [50:0] pr_reg  [NUM_FACES];
    logic signed [63:0] pg_reg  [NUM_FACES];
    logic signed [49:0] pt_reg  [NUM_FACES];
    logic [NUM_FACES-1:0] act3_reg;
    q_t cf3_reg  [NUM_AXES];
    q_t vel3_reg [NUM_AXES];

    always_comb begin
        for (int f = 0; f < NUM_FACES; f++) begin
            pr_next[f] = pm_reg[f] * rest_s;
            pg_next[f] = negd_reg[f] * gain_s;
            pt_next[f] = tang_reg[f] * fric_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            for (int f = 0; f < NUM_FACES; f++) begin
                pr_reg[f] <= pr_next[f];
                // |negd| <= 2^31 and gain < 2^31, so the product fits 64 bits
                pg_reg[f] <= signed'(pg_next[f][63:0]);
                pt_reg[f] <= pt_next[f];
            end
            act3_reg <= act2_reg;
            for (int a = 0; a < NUM_AXES; a++) begin
                cf3_reg[a]  <= cf2_reg[a];
                vel3_reg[a] <= vel2_reg[a];
            end
        end
    end

    // ---------------- stage 4: per-face normal contribution ----------------
    q_t u4  [NUM_FACES];
    q_t tf4 [NUM_FACES];
    q_t c_next [NUM_FACES];
    q_t c_reg  [NUM_FACES];
    logic [NUM_FACES-1:0] act4_reg;
    q_t cf4_reg  [NUM_AXES];
    q_t vel4_reg [NUM_AXES];

    always_comb begin
        for (int f = 0; f < NUM_FACES; f++) begin
            u4[f]  = sat32(64'(qfinish(64'(pr_reg[f]))) + 64'(qfinish(pg_reg[f])));
            tf4[f] = qfinish(64'(pt_reg[f]));
            if (f[0]) begin
                c_next[f] = sat32(-64'(u4[f]) - 64'(tf4[f]));
            end else begin
                c_next[f] = sat32(64'(u4[f]) - 64'(tf4[f]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            for (int f = 0; f < NUM_FACES; f++) begin
                c_reg[f] <= c_next[f];
            end
            act4_reg <= act3_reg;
            for (int a = 0; a < NUM_AXES; a++) begin
                cf4_reg[a]  <= cf3_reg[a];
                vel4_reg[a] <= vel3_reg[a];
            end
        end
    end

    // ---------------- stage 5: accumulate x lower, x upper, y lower ----------------
    q_t imp5_next [NUM_AXES];
    q_t imp5_reg  [NUM_AXES];
    q_t c5_reg    [NUM_FACES];
    logic [NUM_FACES-1:0] act5_reg;
    q_t cf5_reg  [NUM_AXES];
    q_t vel5_reg [NUM_AXES];

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            imp5_next[k] = '0;
        end
        for (int f = 0; f < NUM_FACES / 2; f++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                if (act4_reg[f]) begin
                    imp5_next[k] = sat32(64'(imp5_next[k]) +
                                         64'((k == (f >> 1)) ? c_reg[f] : cf4_reg[k]));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            for (int f = 0; f < NUM_FACES; f++) begin
                c5_reg[f] <= c_reg[f];
            end
            act5_reg <= act4_reg;
            for (int a = 0; a < NUM_AXES; a++) begin
                imp5_reg[a] <= imp5_next[a];
                cf5_reg[a]  <= cf4_reg[a];
                vel5_reg[a] <= vel4_reg[a];
            end
        end
    end

    // ---------------- stage 6: accumulate y upper, z lower, z upper ----------------
    q_t imp6_next [NUM_AXES];
    q_t imp6_reg  [NUM_AXES];
    q_t vel6_reg  [NUM_AXES];

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            imp6_next[k] = imp5_reg[k];
        end
        for (int f = NUM_FACES / 2; f < NUM_FACES; f++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                if (act5_reg[f]) begin
                    imp6_next[k] = sat32(64'(imp6_next[k]) +
                                         64'((k == (f >> 1)) ? c5_reg[f] : cf5_reg[k]));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                imp6_reg[a] <= imp6_next[a];
                vel6_reg[a] <= vel5_reg[a];
            end
        end
    end

    // ---------------- stage 7: new and mid velocity into the output register ----------------
    q_t nv7  [NUM_AXES];
    q_t mid7 [NUM_AXES];
    logic signed [63:0] vsum7 [NUM_AXES];
    abi_out_t out_next;
    abi_out_t out_reg;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            nv7[a]   = sat32(64'(vel6_reg[a]) + 64'(imp6_reg[a]));
            vsum7[a] = (64'(vel6_reg[a]) + 64'(nv7[a])) >>> 1;
            mid7[a]  = q_t'(vsum7[a][31:0]);
        end
        out_next.new_vel_x = nv7[0];
        out_next.new_vel_y = nv7[1];
        out_next.new_vel_z = nv7[2];
        out_next.mid_vel_x = mid7[0];
        out_next.mid_vel_y = mid7[1];
        out_next.mid_vel_z = mid7[2];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            out_reg <= out_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.advance) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], ctrl.in_valid};
        end
    end

    assign out_valid = valid_reg[PIPE_DEPTH-1];
    assign out_item  = out_reg;

`ifndef NO_ASSERTIONS
    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance |=> valid_reg[PIPE_DEPTH-1:1] == $past(valid_reg[PIPE_DEPTH-2:0]))
        else $error("valid bits did not shift with the pipeline");
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance && ctrl.in_valid |=> valid_reg[0])
        else $error("accepted transfer missing from first stage");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.advance |=> $stable(valid_reg) && $stable(out_reg))
        else $error("pipeline moved during a stall");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> valid_reg == '0)
        else $error("valid bits not cleared by reset");
`endif

endmodule

// ===== src/aabb_boundary_impulse.sv =====
// Throughput: one particle per cycle; the seven-stage datapath stalls as a whole
//   only while the output register holds a result that m_ready has not taken.
// Reset (aresetn low, synchronous): pipeline emptied; limits open to the full
//   Q16.16 range, sim_scale and restitution_factor 1.0, friction and position_gain 0.
// Top level: configuration registers and the valid/ready handshake around abi_core.
module aabb_boundary_impulse (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration write port
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_wdata,
    // particle in
    input  logic             s_valid,
    output logic             s_ready,
    input  abi_pkg::abi_in_t  s_data,
    // velocities out
    output logic             m_valid,
    input  logic             m_ready,
    output abi_pkg::abi_out_t m_data
);
    import abi_pkg::*;

    abi_cfg_t  cfg_reg;
    abi_ctrl_t ctrl;
    logic      core_valid;

    // Register file. Writes must arrive only while the pipe is empty; the
    // block does not enforce it. The datapath reads these directly with no
    // shadow copy. Indexes past the list fall to the default arm and are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.limits_x           <= LIMITS_RST;
            cfg_reg.limits_y           <= LIMITS_RST;
            cfg_reg.limits_z           <= LIMITS_RST;
            cfg_reg.sim_scale          <= 31'(1 << Q_FRAC);
            cfg_reg.restitution_factor <= 18'(1 << Q_FRAC);
            cfg_reg.friction           <= '0;
            cfg_reg.position_gain      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LIMITS_X:      cfg_reg.limits_x           <= cfg_wdata;
                REG_LIMITS_Y:      cfg_reg.limits_y           <= cfg_wdata;
                REG_LIMITS_Z:      cfg_reg.limits_z           <= cfg_wdata;
                REG_SIM_SCALE:     cfg_reg.sim_scale          <= cfg_wdata[30:0];
                REG_RESTITUTION:   cfg_reg.restitution_factor <= cfg_wdata[17:0];
                REG_FRICTION:      cfg_reg.friction           <= cfg_wdata[16:0];
                REG_POSITION_GAIN: cfg_reg.position_gain      <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // The whole pipe moves whenever the output register is free or being
    // drained this cycle; a new transfer is taken on every such cycle, so a
    // waiting result never blocks input once m_ready returns. No transfer is
    // taken while in reset.
    assign ctrl.advance  = !core_valid || m_ready;
    assign ctrl.in_valid = s_valid;
    assign s_ready       = aresetn && ctrl.advance;

    abi_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .ctrl     (ctrl),
        .in_item  (s_data),
        .out_valid(core_valid),
        .out_item (m_data)
    );

    assign m_valid = core_valid;

endmodule
